@@ design/biquad_pkg.sv @@
// biquad_pkg: shared types and constants for the biquad wet/dry filter unit
// holds the sequencer state type, register indexes and fixed-point constants
// no dependencies
package biquad_pkg;

	localparam int CFG_INDEX_W = 3;
	localparam int MIX_W       = 17;
	localparam int MIX_FRAC    = 16;
	localparam int ACC_W       = 64;
	localparam int STEP_W      = 3;

	localparam logic [MIX_W-1:0] MIX_ONE = 17'h10000;

	localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

	localparam logic [CFG_INDEX_W-1:0] REG_FEED_0  = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_FEED_1  = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_FEED_2  = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_BACK_1  = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_BACK_2  = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_WET_MIX = 3'd5;

	// multiply-accumulate steps, one product issued per step
	localparam logic [STEP_W-1:0] STEP_TAP_X0  = 3'd0;
	localparam logic [STEP_W-1:0] STEP_TAP_X1  = 3'd1;
	localparam logic [STEP_W-1:0] STEP_TAP_X2  = 3'd2;
	localparam logic [STEP_W-1:0] STEP_TAP_Y1  = 3'd3;
	localparam logic [STEP_W-1:0] STEP_TAP_Y2  = 3'd4;
	localparam logic [STEP_W-1:0] STEP_MAC_END = 3'd5;

	// mix steps: low half product, high half product, last accumulate
	localparam logic [STEP_W-1:0] STEP_MIX_LO  = 3'd0;
	localparam logic [STEP_W-1:0] STEP_MIX_HI  = 3'd1;
	localparam logic [STEP_W-1:0] STEP_MIX_END = 3'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAC,
		ST_ROUND,
		ST_MIX,
		ST_FIN
	} seq_state_t;

endpackage

@@ design/biquad_iir_wet_dry_filter_unit.sv @@
// biquad_iir_wet_dry_filter_unit: direct-form-I biquad with wet/dry mix
// one shared signed multiplier driven by a small sequencer
// depends on biquad_pkg
//
// Usage: samples arrive on the s_ stream and results leave on the m_ stream,
// one result per transfer in. Coefficients (Q2.(COEF_WIDTH-2)) and the wet
// mix (Q1.16, values above one act as one) are written on the cfg channel,
// index 0..5 in the order feed 0, feed 1, feed 2, back 1, back 2, wet mix;
// other indexes are ignored. cfg_ready is always high; write only while idle.
// A new sample is taken only once the last one has left the sequencer:
// the one multiplier forms five filter products and two partial mix products,
// one a cycle, followed by rounding, mix accumulation and saturation. The
// result is held in an output register; m_tvalid and s_tready both rise
// together when it is written. If the receiver stalls, the result
// waits in the output register; a following sample is still taken and runs
// up to its final step, where it waits until the output register is free.
// Reset clears the filter history to zero, sets feed 0 to one, the other
// coefficients to zero and the wet mix to one.
module biquad_iir_wet_dry_filter_unit #(
	parameter int SAMPLE_WIDTH = 24,
	parameter int COEF_WIDTH = 24
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [biquad_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [((COEF_WIDTH > 17) ? COEF_WIDTH : 17)-1:0] cfg_data,
	input  logic s_tvalid,
	output logic s_tready,
	// sample_in
	input  logic [((SAMPLE_WIDTH + 7) / 8) * 8-1:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// sample_out
	output logic [((SAMPLE_WIDTH + 7) / 8) * 8-1:0] m_tdata
);
	import biquad_pkg::*;

	localparam int SW    = SAMPLE_WIDTH;
	localparam int CW    = COEF_WIDTH;
	localparam int CF    = COEF_WIDTH - 2;
	localparam int TDW   = ((SAMPLE_WIDTH + 7) / 8) * 8;
	localparam int AW    = (COEF_WIDTH > 18) ? COEF_WIDTH : 18;
	localparam int BW    = (SAMPLE_WIDTH + 1 > 19) ? SAMPLE_WIDTH + 1 : 19;
	localparam int PW    = AW + BW;
	localparam int DW    = SAMPLE_WIDTH + 19;
	localparam int SUM_W = SAMPLE_WIDTH + 37;

	localparam logic signed [CW-1:0] COEF_ONE = CW'(1) <<< CF;
	localparam logic signed [ACC_W-1:0] ACC_HALF = ACC_W'(1) <<< (CF - 1);
	localparam logic signed [ACC_W-1:0] FILT_MAX = (ACC_W'(1) <<< (SW + 17)) - ACC_W'(1);
	localparam logic signed [ACC_W-1:0] FILT_MIN = -(ACC_W'(1) <<< (SW + 17));
	localparam logic signed [SUM_W-1:0] MIX_HALF = SUM_W'(1) <<< (MIX_FRAC - 1);
	localparam logic signed [SUM_W-1:0] Y_MAX = (SUM_W'(1) <<< (SW - 1)) - SUM_W'(1);
	localparam logic signed [SUM_W-1:0] Y_MIN = -(SUM_W'(1) <<< (SW - 1));

	seq_state_t state_q, state_d;
	logic [STEP_W-1:0] step_q;

	logic signed [CW-1:0] coef_feed_0_q, coef_feed_1_q, coef_feed_2_q;
	logic signed [CW-1:0] coef_back_1_q, coef_back_2_q;
	logic [MIX_W-1:0] wet_mix_q, mix_eff;

	logic signed [SW-1:0] x_q, x1_q, x2_q, y1_q, y2_q, y_out_q;
	logic out_valid_q, out_free;

	logic signed [AW-1:0] mul_a;
	logic signed [BW-1:0] mul_b;
	logic signed [PW-1:0] prod_q;

	logic signed [ACC_W-1:0] acc_q, acc_sat, rnd_sat, filt, filt_c;
	logic signed [ACC_W:0] acc_sum, rnd_sum;
	logic signed [DW-1:0] d_q;
	logic signed [SUM_W-1:0] sum_q, y_rnd, y_sh, y_c;
	logic signed [SW-1:0] y_fin;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_IDLE);
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = TDW'($unsigned(y_out_q));
	assign out_free  = !out_valid_q || m_tready;
	assign mix_eff   = (wet_mix_q > MIX_ONE) ? MIX_ONE : wet_mix_q;

	// shared multiplier operands
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		if (state_q == ST_MIX) begin
			mul_a = AW'($signed({1'b0, mix_eff}));
			if (step_q == STEP_MIX_LO) begin
				mul_b = BW'($signed({1'b0, d_q[SW-1:0]}));
			end else begin
				mul_b = BW'($signed(d_q[DW-1:SW]));
			end
		end else begin
			case (step_q)
				STEP_TAP_X0: begin
					mul_a = AW'(coef_feed_0_q);
					mul_b = BW'(x_q);
				end
				STEP_TAP_X1: begin
					mul_a = AW'(coef_feed_1_q);
					mul_b = BW'(x1_q);
				end
				STEP_TAP_X2: begin
					mul_a = AW'(coef_feed_2_q);
					mul_b = BW'(x2_q);
				end
				STEP_TAP_Y1: begin
					mul_a = AW'(coef_back_1_q);
					mul_b = -BW'(y1_q);
				end
				STEP_TAP_Y2: begin
					mul_a = AW'(coef_back_2_q);
					mul_b = -BW'(y2_q);
				end
				default: begin
					mul_a = '0;
					mul_b = '0;
				end
			endcase
		end
	end

	// saturating accumulate, rounding and clamping
	always_comb begin
		acc_sum = (ACC_W + 1)'(acc_q) + (ACC_W + 1)'(prod_q);
		if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
			acc_sat = acc_sum[ACC_W] ? ACC_MIN : ACC_MAX;
		end else begin
			acc_sat = acc_sum[ACC_W-1:0];
		end
		rnd_sum = (ACC_W + 1)'(acc_q) + (ACC_W + 1)'(ACC_HALF);
		if (rnd_sum[ACC_W] != rnd_sum[ACC_W-1]) begin
			rnd_sat = ACC_MAX;
		end else begin
			rnd_sat = rnd_sum[ACC_W-1:0];
		end
		filt = rnd_sat >>> CF;
		if (filt > FILT_MAX) begin
			filt_c = FILT_MAX;
		end else if (filt < FILT_MIN) begin
			filt_c = FILT_MIN;
		end else begin
			filt_c = filt;
		end
		y_rnd = sum_q + MIX_HALF;
		y_sh  = y_rnd >>> MIX_FRAC;
		if (y_sh > Y_MAX) begin
			y_c = Y_MAX;
		end else if (y_sh < Y_MIN) begin
			y_c = Y_MIN;
		end else begin
			y_c = y_sh;
		end
		y_fin = SW'(y_c);
	end

	// sequencer next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_d = ST_MAC;
				end
			end
			ST_MAC: begin
				if (step_q == STEP_MAC_END) begin
					state_d = ST_ROUND;
				end
			end
			ST_ROUND: begin
				state_d = ST_MIX;
			end
			ST_MIX: begin
				if (step_q == STEP_MIX_END) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			step_q        <= '0;
			coef_feed_0_q <= COEF_ONE;
			coef_feed_1_q <= '0;
			coef_feed_2_q <= '0;
			coef_back_1_q <= '0;
			coef_back_2_q <= '0;
			wet_mix_q     <= MIX_ONE;
			x1_q          <= '0;
			x2_q          <= '0;
			y1_q          <= '0;
			y2_q          <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_d != state_q) begin
				step_q <= '0;
			end else begin
				step_q <= step_q + STEP_W'(1);
			end
			if (cfg_valid) begin
				case (cfg_index)
					REG_FEED_0:  coef_feed_0_q <= cfg_data[CW-1:0];
					REG_FEED_1:  coef_feed_1_q <= cfg_data[CW-1:0];
					REG_FEED_2:  coef_feed_2_q <= cfg_data[CW-1:0];
					REG_BACK_1:  coef_back_1_q <= cfg_data[CW-1:0];
					REG_BACK_2:  coef_back_2_q <= cfg_data[CW-1:0];
					REG_WET_MIX: wet_mix_q     <= cfg_data[MIX_W-1:0];
					default: begin
					end
				endcase
			end
			if (state_q == ST_FIN && out_free) begin
				x2_q        <= x1_q;
				x1_q        <= x_q;
				y2_q        <= y1_q;
				y1_q        <= y_fin;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					x_q   <= s_tdata[SW-1:0];
					acc_q <= '0;
				end
			end
			ST_MAC: begin
				if (step_q != STEP_TAP_X0) begin
					acc_q <= acc_sat;
				end
			end
			ST_ROUND: begin
				d_q   <= DW'(filt_c) - DW'(x_q);
				sum_q <= SUM_W'(x_q) <<< MIX_FRAC;
			end
			ST_MIX: begin
				if (step_q == STEP_MIX_HI) begin
					sum_q <= sum_q + SUM_W'(prod_q);
				end else if (step_q == STEP_MIX_END) begin
					sum_q <= sum_q + (SUM_W'(prod_q) <<< SW);
				end
			end
			ST_FIN: begin
				if (out_free) begin
					y_out_q <= y_fin;
				end
			end
			default: begin
			end
		endcase
	end

endmodule
